/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define CBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds across reset
`define CBE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* src/cbe_pkg.sv */
`default_nettype none
package cbe_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int LVL_W      = 8;
    localparam int MODE_W     = 2;
    localparam int PCT_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERCENT      = 1'd1;

    // balance modes
    localparam logic [MODE_W-1:0] MODE_WHITE_PATCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY_WORLD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PERCENTILE  = 2'd2;

    // item operations
    localparam logic OP_STAT = 1'b0;
    localparam logic OP_CORR = 1'b1;

    // reset values of the registers
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_WHITE_PATCH;
    localparam logic [PCT_W-1:0]  PCT_RESET  = 14'd500;

    // arithmetic constants
    localparam logic [PIX_W-1:0]  TARGET_WHITE = 8'd255;
    localparam logic [PIX_W-1:0]  TARGET_GRAY  = 8'd128;
    localparam logic [PCT_W-1:0]  PCT_SCALE    = 14'd10000;
    localparam logic [13:0]       COEF_R       = 14'd4899;
    localparam logic [13:0]       COEF_G       = 14'd9617;
    localparam logic [13:0]       COEF_B       = 14'd1868;
    localparam logic [21:0]       LUMA_ROUND   = 22'd8192;
    localparam int                LUMA_SHIFT   = 14;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_blue;
        logic [PIX_W-1:0] pixel_green;
        logic [PIX_W-1:0] pixel_red;
        logic             frame_end;
    } t_item_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             out_frame_end;
    } t_item_out;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_STAT,
        ST_PREP,
        ST_WALK_RD,
        ST_WALK_ACC,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_STORE
    } t_state;

    typedef struct packed {
        logic idle;
        logic clear_wr;
        logic stat_wr;
        logic walk_start;
        logic walk_rd;
        logic walk_acc;
        logic div_load;
        logic div_step;
        logic div_store;
    } t_ctl_cmd;

    typedef struct packed {
        logic stat_go;
        logic frame_end;
        logic lvl_last;
        logic div_last;
        logic chan_last;
    } t_ctl_sts;

endpackage
`default_nettype wire

/* src/cbe_ctrl.sv */
`default_nettype none
module cbe_ctrl
    import cbe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          o_busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:      if (i_sts.lvl_last) n_state = ST_IDLE;
            ST_IDLE:      if (i_sts.stat_go) n_state = ST_STAT;
            ST_STAT:      n_state = i_sts.frame_end ? ST_PREP : ST_IDLE;
            ST_PREP:      n_state = ST_WALK_RD;
            ST_WALK_RD:   n_state = ST_WALK_ACC;
            ST_WALK_ACC:  n_state = i_sts.lvl_last ? ST_DIV_LOAD : ST_WALK_RD;
            ST_DIV_LOAD:  n_state = ST_DIV_STEP;
            ST_DIV_STEP:  if (i_sts.div_last) n_state = ST_DIV_STORE;
            ST_DIV_STORE: n_state = i_sts.chan_last ? ST_IDLE : ST_DIV_LOAD;
            default:      n_state = ST_INIT;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_INIT:      o_cmd.clear_wr   = 1'b1;
            ST_IDLE:      o_cmd.idle       = 1'b1;
            ST_STAT:      o_cmd.stat_wr    = 1'b1;
            ST_PREP:      o_cmd.walk_start = 1'b1;
            ST_WALK_RD:   o_cmd.walk_rd    = 1'b1;
            ST_WALK_ACC:  o_cmd.walk_acc   = 1'b1;
            ST_DIV_LOAD:  o_cmd.div_load   = 1'b1;
            ST_DIV_STEP:  o_cmd.div_step   = 1'b1;
            ST_DIV_STORE: o_cmd.div_store  = 1'b1;
            default:      o_cmd            = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

/* src/cbe_datapath.sv */
`default_nettype none
module cbe_datapath
    import cbe_pkg::*;
#(
    parameter int MAX_PIXELS_LOG2    = 22,
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl_cmd              i_cmd,
    output t_ctl_sts                   o_sts,
    input  wire logic                  i_start,
    input  wire t_item_in              i_item,
    output logic                       o_result_valid,
    output t_item_out                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W  = MAX_PIXELS_LOG2;
    localparam int SUM_W  = MAX_PIXELS_LOG2 + PIX_W;
    localparam int ENT_W  = CNT_W + 3 * SUM_W;
    localparam int PRD_W  = MAX_PIXELS_LOG2 + PCT_W;
    localparam int QW     = GAIN_FRACTION_BITS + PIX_W;
    localparam int DW     = SUM_W;
    localparam int NW     = SUM_W + GAIN_FRACTION_BITS + 1;
    localparam int BIT_W  = $clog2(NW);
    localparam int LEVELS = 1 << LVL_W;
    localparam logic [CNT_W-1:0] TOTAL_MAX = {CNT_W{1'b1}};
    localparam logic [QW-1:0]    GAIN_MAX  = {QW{1'b1}};
    localparam logic [QW+PIX_W-1:0] ROUND_HALF =
        (QW+PIX_W)'(1) << (GAIN_FRACTION_BITS - 1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sb;
        logic [SUM_W-1:0] sg;
        logic [SUM_W-1:0] sr;
    } t_entry;

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [PCT_W-1:0]  r_pct;

    // histogram memory
    logic [ENT_W-1:0] r_mem [LEVELS];
    logic [ENT_W-1:0] r_rdata;
    t_entry           rd_ent;
    t_entry           wr_ent;
    logic             mem_re;
    logic [LVL_W-1:0] mem_ra;
    logic             mem_we;
    logic [LVL_W-1:0] mem_wa;

    // statistics registers
    t_item_in         r_pix;
    logic [LVL_W-1:0] r_y;
    logic [LVL_W-1:0] in_y;
    logic [21:0]      luma_sum;
    logic [CNT_W-1:0] r_total;
    logic [LVL_W-1:0] r_bright_y;
    logic [PIX_W-1:0] r_bright_b;
    logic [PIX_W-1:0] r_bright_g;
    logic [PIX_W-1:0] r_bright_r;
    logic             stat_take;

    // walk registers
    logic [LVL_W-1:0] r_lvl;
    logic [CNT_W-1:0] r_cum;
    logic [PRD_W-1:0] r_need;
    logic [CNT_W-1:0] r_acc_cnt;
    logic [SUM_W-1:0] r_acc_b;
    logic [SUM_W-1:0] r_acc_g;
    logic [SUM_W-1:0] r_acc_r;
    logic [PRD_W-1:0] cum_scaled;
    logic             lvl_take;

    // divider registers
    logic [1:0]       r_chan;
    logic [BIT_W-1:0] r_bit;
    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_den;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic             r_ovf;
    logic [QW-1:0]    r_gain [3];
    logic [DW:0]      rem_sh;
    logic             q_bit;
    logic [SUM_W-1:0] tw;
    logic [DW-1:0]    ref_sel;
    logic             use_bright;

    logic             accept;
    logic             corr_go;

    // correction of one channel: multiply, round, saturate
    function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0] v,
                                                     input logic [QW-1:0] g);
        logic [QW+PIX_W-1:0] prod;
        logic [QW+PIX_W-1:0] shifted;
        prod    = (QW+PIX_W)'(v) * (QW+PIX_W)'(g) + ROUND_HALF;
        shifted = prod >> GAIN_FRACTION_BITS;
        apply_gain = (shifted > (QW+PIX_W)'(8'd255)) ? 8'd255 : shifted[PIX_W-1:0];
    endfunction

    assign accept  = i_start & i_cmd.idle;
    assign corr_go = accept & (i_item.operation == OP_CORR);

    // luma of the incoming pixel
    assign luma_sum = 22'(COEF_R * 22'(i_item.pixel_red)) +
                      22'(COEF_G * 22'(i_item.pixel_green)) +
                      22'(COEF_B * 22'(i_item.pixel_blue)) + LUMA_ROUND;
    assign in_y = luma_sum[LUMA_SHIFT +: LVL_W];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_pct  <= PCT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BALANCE_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_PERCENT:      r_pct  <= i_cfg_data[PCT_W-1:0];
                default:          r_mode <= r_mode;
            endcase
        end
    end

    // memory port control
    assign rd_ent    = r_rdata;
    assign stat_take = (r_total < TOTAL_MAX);
    assign mem_re    = (accept & (i_item.operation == OP_STAT)) | i_cmd.walk_rd;
    assign mem_ra    = i_cmd.walk_rd ? r_lvl : in_y;
    assign mem_we    = i_cmd.clear_wr | i_cmd.walk_acc | (i_cmd.stat_wr & stat_take);
    assign mem_wa    = i_cmd.stat_wr ? r_y : r_lvl;

    always_comb begin
        wr_ent = '0;
        if (i_cmd.stat_wr) begin
            wr_ent.cnt = rd_ent.cnt + CNT_W'(1);
            wr_ent.sb  = rd_ent.sb + SUM_W'(r_pix.pixel_blue);
            wr_ent.sg  = rd_ent.sg + SUM_W'(r_pix.pixel_green);
            wr_ent.sr  = rd_ent.sr + SUM_W'(r_pix.pixel_red);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= wr_ent;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // capture of each accepted item, used by the statistics write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_item;
            r_y   <= in_y;
        end
    end

    // pixel total and brightest pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_bright_y <= '0;
        end else if (i_cmd.walk_start) begin
            r_total <= '0;
        end else if (i_cmd.stat_wr && stat_take) begin
            r_total <= r_total + CNT_W'(1);
            if (r_total == '0 || r_y > r_bright_y) begin
                r_bright_y <= r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stat_wr && stat_take && (r_total == '0 || r_y > r_bright_y)) begin
            r_bright_b <= r_pix.pixel_blue;
            r_bright_g <= r_pix.pixel_green;
            r_bright_r <= r_pix.pixel_red;
        end
    end

    // level counter, counts down for the clearing pass and the bin walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '1;
        end else if (i_cmd.walk_start) begin
            r_lvl <= '1;
        end else if (i_cmd.clear_wr || i_cmd.walk_acc) begin
            r_lvl <= r_lvl - LVL_W'(1);
        end
    end

    // percentile test: cum(level) * 10000 >= total * (10000 - p)
    assign cum_scaled = PRD_W'(r_cum) * PRD_W'(PCT_SCALE);

    always_comb begin
        case (r_mode)
            MODE_GRAY_WORLD: lvl_take = 1'b1;
            MODE_PERCENTILE: lvl_take = (cum_scaled >= r_need);
            default:         lvl_take = 1'b0;
        endcase
    end

    // bin walk accumulation, from the top level down
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_cum     <= r_total;
            r_need    <= (r_pct >= PCT_SCALE) ? '0 :
                         PRD_W'(r_total) * PRD_W'(PCT_SCALE - r_pct);
            r_acc_cnt <= '0;
            r_acc_b   <= '0;
            r_acc_g   <= '0;
            r_acc_r   <= '0;
        end else if (i_cmd.walk_acc && lvl_take) begin
            r_cum     <= r_cum - rd_ent.cnt;
            r_acc_cnt <= r_acc_cnt + rd_ent.cnt;
            r_acc_b   <= r_acc_b + rd_ent.sb;
            r_acc_g   <= r_acc_g + rd_ent.sg;
            r_acc_r   <= r_acc_r + rd_ent.sr;
        end
    end

    // dividend and divisor for the current channel
    assign use_bright = (r_mode != MODE_GRAY_WORLD) && (r_mode != MODE_PERCENTILE);

    always_comb begin
        if (use_bright) begin
            tw = SUM_W'(TARGET_WHITE);
        end else if (r_mode == MODE_GRAY_WORLD) begin
            tw = SUM_W'(r_acc_cnt) << 7;
        end else begin
            tw = SUM_W'(r_acc_cnt) * SUM_W'(TARGET_WHITE);
        end
        case (r_chan)
            2'd0:    ref_sel = use_bright ? DW'(r_bright_b) : r_acc_b;
            2'd1:    ref_sel = use_bright ? DW'(r_bright_g) : r_acc_g;
            default: ref_sel = use_bright ? DW'(r_bright_r) : r_acc_r;
        endcase
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num <= ({tw, GAIN_FRACTION_BITS'(0)} + NW'(ref_sel >> 1));
            r_den <= ref_sel;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
            r_bit <= BIT_W'(NW - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[QW-2:0], q_bit};
            r_ovf <= r_ovf | r_quo[QW-1];
            r_bit <= r_bit - BIT_W'(1);
        end
    end

    // channel index and gain store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan    <= '0;
            r_gain[0] <= '0;
            r_gain[1] <= '0;
            r_gain[2] <= '0;
        end else if (i_cmd.walk_start) begin
            r_chan <= '0;
        end else if (i_cmd.div_store) begin
            r_gain[r_chan] <= (r_den == '0) ? '0 : (r_ovf ? GAIN_MAX : r_quo);
            r_chan         <= r_chan + 2'd1;
        end
    end

    // correction pixel result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= corr_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (corr_go) begin
            o_result.out_blue      <= apply_gain(i_item.pixel_blue, r_gain[0]);
            o_result.out_green     <= apply_gain(i_item.pixel_green, r_gain[1]);
            o_result.out_red       <= apply_gain(i_item.pixel_red, r_gain[2]);
            o_result.out_frame_end <= i_item.frame_end;
        end
    end

    // status to the controller
    assign o_sts.stat_go   = accept & (i_item.operation == OP_STAT);
    assign o_sts.frame_end = r_pix.frame_end;
    assign o_sts.lvl_last  = (r_lvl == '0);
    assign o_sts.div_last  = (r_bit == '0);
    assign o_sts.chan_last = (r_chan == 2'd2);

endmodule
`default_nettype wire

/* src/color_balance_engine_unit.sv */
`default_nettype none
// Frame white balance in two passes. Statistics pixels (operation 0) take a
// read of the luma histogram memory when accepted and a write in the ST_STAT
// state, with busy high during the write. The statistics pixel marked
// frame_end then starts the gain computation: a walk down the 256 histogram
// levels, clearing each level as it goes, and three restoring divisions, one
// per channel, each with a load and a store step. Correction pixels
// (operation 1) are accepted every cycle while idle; each result appears
// with o_result_valid in the cycle after its item and lasts exactly one
// cycle, since the receiver cannot stall. After reset the block clears all
// 256 histogram levels with busy high. Configuration registers are read
// throughout the gain computation, so write them only while busy is low; a
// write acts at the next gain computation.
module color_balance_engine_unit
    import cbe_pkg::*;
#(
    parameter int MAX_PIXELS_LOG2    = 22,
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_item_in              i_item,
    output logic                       o_result_valid,
    output t_item_out                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // sequencer
    cbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // histogram, divider and correction datapath
    cbe_datapath #(
        .MAX_PIXELS_LOG2    (MAX_PIXELS_LOG2),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_start        (i_start),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

endmodule
`default_nettype wire

/* src/cbe_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module cbe_checker
    import cbe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  o_busy,
    input  wire t_item_in              i_item,
    input  wire logic                  o_result_valid
);

    logic acc_stat;
    logic acc_corr;

    assign acc_stat = i_start && !o_busy && (i_item.operation == OP_STAT);
    assign acc_corr = i_start && !o_busy && (i_item.operation == OP_CORR);

    // reset starts the histogram clearing pass
    `CBE_ASSERT_ALWAYS(a_reset_busy, i_clk, !i_rst_n |=> o_busy)
    // an accepted statistics item makes the block busy for its histogram write
    `CBE_ASSERT(a_stat_busy, i_clk, i_rst_n, acc_stat |=> o_busy)
    // every correction item gives its result in the next cycle
    `CBE_ASSERT(a_corr_result, i_clk, i_rst_n, acc_corr |=> o_result_valid)
    // no result without a correction item the cycle before
    `CBE_ASSERT(a_no_spurious, i_clk, i_rst_n, o_result_valid |-> $past(acc_corr))

endmodule

bind color_balance_engine_unit cbe_checker u_cbe_checker (.*);
`default_nettype wire
